>>> hdl/gtm_pkg.sv
// ----------------------------------------------------------------------------
// gtm_pkg
// Shared types, constants and helpers for the Goertzel tone magnitude block.
// ----------------------------------------------------------------------------
`default_nettype none

package gtm_pkg;

    // default datapath sizing
    localparam int ACC_WIDTH_DEF = 40;
    localparam int FRAC_BITS_DEF = 14;

    // coefficient format, fixed by the register widths
    localparam int COEF_FRAC = 14;
    localparam int COEFF_W   = 17;
    localparam int TRIG_W    = 16;
    localparam int SAMPLE_W  = 8;
    localparam int LEN_W     = 8;
    localparam int MAG_W     = 16;
    localparam int BAR_W     = 8;

    // magnitude datapath: integer part limit and fraction kept before squaring
    localparam int MAG_INT_BITS = 17;
    localparam int MAG_FRAC     = 8;
    localparam int SQ_IN_W      = MAG_INT_BITS + MAG_FRAC;
    localparam int ROOT_W       = SQ_IN_W + 1;
    localparam int ROOT_SHIFT   = 9;

    // configuration port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [LEN_W-1:0] BLOCK_LENGTH_RST = LEN_W'(115);
    localparam logic [MAG_W-1:0] DETECT_THR_RST   = MAG_W'(900);

    // register index, byte address / 4
    typedef enum logic [2:0] {
        REG_COEFF     = 3'd0,
        REG_COSINE    = 3'd1,
        REG_SINE      = 3'd2,
        REG_BLOCK_LEN = 3'd3,
        REG_DETECT    = 3'd4
    } t_reg_idx;

    // configuration bundle seen by the datapath
    typedef struct packed {
        logic [COEFF_W-1:0] coeff_q14;
        logic [TRIG_W-1:0]  cosine_q14;
        logic [TRIG_W-1:0]  sine_q14;
        logic [LEN_W-1:0]   block_length;
        logic [MAG_W-1:0]   detect_threshold;
    } t_cfg;

    // one queued sample with its end-of-block mark
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } t_item;

    // bar graph thresholds, increasing
    localparam logic [MAG_W-1:0] BAR_THRESH [BAR_W] = '{
        16'd200, 16'd210, 16'd220, 16'd260, 16'd300, 16'd350, 16'd380, 16'd400
    };

    // one bit per threshold that the magnitude exceeds
    function automatic logic [BAR_W-1:0] bar_code(input logic [MAG_W-1:0] mag);
        logic [BAR_W-1:0] code;
        code = '0;
        for (int i = 0; i < BAR_W; i++) begin
            code[i] = (mag > BAR_THRESH[i]);
        end
        return code;
    endfunction

endpackage

`default_nettype wire

>>> hdl/gtm_regs.sv
// ----------------------------------------------------------------------------
// gtm_regs
// APB-style configuration registers: coefficients, block length, threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module gtm_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_psel,
    input  wire logic                       i_penable,
    input  wire logic                       i_pwrite,
    input  wire logic [gtm_pkg::APB_AW-1:0] i_paddr,
    input  wire logic [gtm_pkg::APB_DW-1:0] i_pwdata,
    output logic      [gtm_pkg::APB_DW-1:0] o_prdata,
    output logic                            o_pready,
    output gtm_pkg::t_cfg                   o_cfg
);
    import gtm_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign o_pready = 1'b1;
    assign w_idx    = t_reg_idx'(i_paddr[APB_AW-1:2]);
    assign w_wr     = i_psel & i_penable & i_pwrite & o_pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coeff_q14        <= '0;
            r_cfg.cosine_q14       <= '0;
            r_cfg.sine_q14         <= '0;
            r_cfg.block_length     <= BLOCK_LENGTH_RST;
            r_cfg.detect_threshold <= DETECT_THR_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_COEFF:     r_cfg.coeff_q14        <= i_pwdata[COEFF_W-1:0];
                REG_COSINE:    r_cfg.cosine_q14       <= i_pwdata[TRIG_W-1:0];
                REG_SINE:      r_cfg.sine_q14         <= i_pwdata[TRIG_W-1:0];
                REG_BLOCK_LEN: r_cfg.block_length     <= i_pwdata[LEN_W-1:0];
                REG_DETECT:    r_cfg.detect_threshold <= i_pwdata[MAG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_COEFF:     o_prdata = APB_DW'(r_cfg.coeff_q14);
            REG_COSINE:    o_prdata = APB_DW'(r_cfg.cosine_q14);
            REG_SINE:      o_prdata = APB_DW'(r_cfg.sine_q14);
            REG_BLOCK_LEN: o_prdata = APB_DW'(r_cfg.block_length);
            REG_DETECT:    o_prdata = APB_DW'(r_cfg.detect_threshold);
            default:       o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> hdl/gtm_front.sv
// ----------------------------------------------------------------------------
// gtm_front
// Sample intake: counts samples, marks the last of each block and queues
// the items for the recurrence engine.
// ----------------------------------------------------------------------------
`default_nettype none

module gtm_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    output logic                              o_full,
    input  wire logic [gtm_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic [gtm_pkg::LEN_W-1:0]    i_block_length,
    output gtm_pkg::t_item                    o_item,
    output logic                              o_empty,
    input  wire logic                         i_pop
);
    import gtm_pkg::*;

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int FILL_W = $clog2(QDEPTH + 1);

    t_item             r_mem [QDEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic [LEN_W-1:0]  r_cnt;
    logic [LEN_W-1:0]  n_cnt;
    logic              w_last;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_fill == FILL_W'(QDEPTH));
    assign o_empty = (r_fill == '0);
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & ~o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    // block position, count wraps at 256
    assign n_cnt  = r_cnt + LEN_W'(1);
    assign w_last = (n_cnt == i_block_length);

    // sample counter and queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_cnt    <= w_last ? '0 : n_cnt;
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_fill <= r_fill + FILL_W'(1);
                2'b01:   r_fill <= r_fill - FILL_W'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr].sample <= i_sample;
            r_mem[r_wr_ptr].last   <= w_last;
        end
    end

endmodule

`default_nettype wire

>>> hdl/gtm_mac.sv
// ----------------------------------------------------------------------------
// gtm_mac
// Goertzel recurrence engine: q0 = coeff*q1 - q2 + sample, one item at a
// time, handing the delay line to the magnitude unit at each block end.
// ----------------------------------------------------------------------------
`default_nettype none

module gtm_mac #(
    parameter int ACC_WIDTH = gtm_pkg::ACC_WIDTH_DEF,
    parameter int FRAC_BITS = gtm_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [gtm_pkg::COEFF_W-1:0]   i_coeff,
    input  wire gtm_pkg::t_item                i_item,
    input  wire logic                          i_q_empty,
    output logic                               o_q_pop,
    output logic                               o_hand_valid,
    input  wire logic                          i_hand_ready,
    output logic      [ACC_WIDTH-1:0]          o_q1,
    output logic      [ACC_WIDTH-1:0]          o_q2
);
    import gtm_pkg::*;

    localparam int PROD_W = ACC_WIDTH + COEFF_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_HAND
    } t_state;

    t_state                    r_state;
    logic [ACC_WIDTH-1:0]      r_q1;
    logic [ACC_WIDTH-1:0]      r_q2;
    logic [SAMPLE_W-1:0]       r_smp;
    logic                      r_last;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  w_scaled;
    logic [ACC_WIDTH-1:0]      w_ins;
    logic [ACC_WIDTH-1:0]      w_q0;

    assign o_q_pop      = (r_state == S_IDLE) & ~i_q_empty;
    assign o_hand_valid = (r_state == S_HAND);
    assign o_q1         = r_q1;
    assign o_q2         = r_q2;

    // floor scaling of the product, sample aligned to the fraction point
    assign w_scaled = r_prod >>> COEF_FRAC;
    assign w_ins    = ACC_WIDTH'(r_smp) << FRAC_BITS;
    assign w_q0     = w_scaled[ACC_WIDTH-1:0] - r_q2 + w_ins;

    // sequencer and delay line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_q1    <= '0;
            r_q2    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_smp   <= i_item.sample;
                        r_last  <= i_item.last;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= $signed(r_q1) * $signed(i_coeff);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_q2    <= r_q1;
                    r_q1    <= w_q0;
                    r_state <= r_last ? S_HAND : S_IDLE;
                end
                S_HAND: begin
                    if (i_hand_ready) begin
                        r_q1    <= '0;
                        r_q2    <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/gtm_mag.sv
// ----------------------------------------------------------------------------
// gtm_mag
// Block-end magnitude unit: real/imag terms, squares, bit-serial square root,
// bar code and tone flag, with the result register toward the output.
// ----------------------------------------------------------------------------
`default_nettype none

module gtm_mag #(
    parameter int ACC_WIDTH = gtm_pkg::ACC_WIDTH_DEF,
    parameter int FRAC_BITS = gtm_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire gtm_pkg::t_cfg                i_cfg,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [ACC_WIDTH-1:0]         i_q1,
    input  wire logic [ACC_WIDTH-1:0]         i_q2,
    output logic                              o_out_valid,
    input  wire logic                         i_out_pop,
    output logic      [gtm_pkg::MAG_W-1:0]    o_magnitude,
    output logic      [gtm_pkg::BAR_W-1:0]    o_bar_level,
    output logic                              o_tone_detected
);
    import gtm_pkg::*;

    localparam int PROD_W  = ACC_WIDTH + TRIG_W;
    localparam int OVF_SH  = FRAC_BITS + MAG_INT_BITS;
    localparam int DOWN_SH = FRAC_BITS - MAG_FRAC;
    localparam int SQ_W    = 2 * SQ_IN_W;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 1;
    localparam int TRY_W   = ROOT_W + 3;
    localparam int STEP_W  = $clog2(ROOT_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COS,
        S_SIN,
        S_ABS,
        S_SQR,
        S_SUM,
        S_ROOT,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [ACC_WIDTH-1:0]     r_q1;
    logic [ACC_WIDTH-1:0]     r_q2;
    logic signed [PROD_W-1:0] r_prod;
    logic [ACC_WIDTH-1:0]     r_re;
    logic                     r_sat;
    logic [SQ_IN_W-1:0]       r_ar;
    logic [SQ_IN_W-1:0]       r_ai;
    logic [SQ_W-1:0]          r_sq;
    logic [RAD_W-1:0]         r_rad;
    logic [REM_W-1:0]         r_rem;
    logic [ROOT_W-1:0]        r_root;
    logic [STEP_W-1:0]        r_step;
    logic                     r_out_valid;
    logic [MAG_W-1:0]         r_mag;
    logic [BAR_W-1:0]         r_bar;
    logic                     r_tone;

    logic signed [PROD_W-1:0] w_scaled;
    logic [ACC_WIDTH-1:0]     w_im;
    logic [ACC_WIDTH-1:0]     w_abs_re;
    logic [ACC_WIDTH-1:0]     w_abs_im;
    logic [ACC_WIDTH-1:0]     w_sh_re;
    logic [ACC_WIDTH-1:0]     w_sh_im;
    logic                     w_ovf;
    logic [SQ_W-1:0]          w_sq_im;
    logic [TRY_W-1:0]         w_rem_sh;
    logic [TRY_W-1:0]         w_try;
    logic                     w_fit;
    logic [TRY_W-1:0]         w_rem_new;
    logic [ROOT_W-ROOT_SHIFT-1:0] w_root_top;
    logic [MAG_W-1:0]         w_mag;

    assign o_ready         = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_magnitude     = r_mag;
    assign o_bar_level     = r_bar;
    assign o_tone_detected = r_tone;

    // floor-scaled product of q2 with cosine or sine
    assign w_scaled = r_prod >>> COEF_FRAC;
    assign w_im     = w_scaled[ACC_WIDTH-1:0];

    // magnitudes, range check and alignment to eight fraction bits
    assign w_abs_re = r_re[ACC_WIDTH-1] ? (~r_re + ACC_WIDTH'(1)) : r_re;
    assign w_abs_im = w_im[ACC_WIDTH-1] ? (~w_im + ACC_WIDTH'(1)) : w_im;
    assign w_ovf    = ((w_abs_re >> OVF_SH) != '0) | ((w_abs_im >> OVF_SH) != '0);
    assign w_sh_re  = w_abs_re >> DOWN_SH;
    assign w_sh_im  = w_abs_im >> DOWN_SH;

    assign w_sq_im = r_ai * r_ai;

    // one root digit per step
    assign w_rem_sh  = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_try     = {1'b0, r_root, 2'b01};
    assign w_fit     = (w_rem_sh >= w_try);
    assign w_rem_new = w_fit ? (w_rem_sh - w_try) : w_rem_sh;

    // final scaling and saturation
    assign w_root_top = r_root[ROOT_W-1:ROOT_SHIFT];
    always_comb begin
        if (r_sat || (w_root_top[ROOT_W-ROOT_SHIFT-1:MAG_W] != '0)) begin
            w_mag = '1;
        end else begin
            w_mag = w_root_top[MAG_W-1:0];
        end
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_sat <= 1'b0;
                    if (i_valid) begin
                        r_q1    <= i_q1;
                        r_q2    <= i_q2;
                        r_state <= S_COS;
                    end
                end
                S_COS: begin
                    r_prod  <= $signed(r_q2) * $signed(i_cfg.cosine_q14);
                    r_state <= S_SIN;
                end
                S_SIN: begin
                    r_re    <= r_q1 - w_scaled[ACC_WIDTH-1:0];
                    r_prod  <= $signed(r_q2) * $signed(i_cfg.sine_q14);
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    r_ar <= w_sh_re[SQ_IN_W-1:0];
                    r_ai <= w_sh_im[SQ_IN_W-1:0];
                    if (w_ovf) begin
                        r_sat   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SQR;
                    end
                end
                S_SQR: begin
                    r_sq    <= r_ar * r_ar;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_rad   <= RAD_W'(r_sq) + RAD_W'(w_sq_im);
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_step  <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_rem  <= w_rem_new[REM_W-1:0];
                    r_root <= {r_root[ROOT_W-2:0], w_fit};
                    r_rad  <= r_rad << 2;
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(ROOT_W - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid) begin
                        r_mag       <= w_mag;
                        r_bar       <= bar_code(w_mag);
                        r_tone      <= (w_mag > i_cfg.detect_threshold);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/goertzel_tone_magnitude.sv
// ----------------------------------------------------------------------------
// goertzel_tone_magnitude
// Single-bin Goertzel tone detector with magnitude, bar code and tone flag.
// ----------------------------------------------------------------------------
// Samples are pushed into a two-entry queue that tags the last sample of each
// block; the recurrence engine takes one queued sample at a time through
// queue fetch, the q1 * coeff multiply and then the accumulate, plus a
// handoff state at the end of a block. The magnitude of a finished block is
// worked out by its own unit (two coefficient multiplies, two squares and a
// 26-step square root), overlapping the next block, and lands in a one-deep
// result register read through empty/pop. full drops again as soon as the
// engine frees a queue entry. No clearing pass follows reset.
`default_nettype none

module goertzel_tone_magnitude #(
    parameter int ACC_WIDTH = gtm_pkg::ACC_WIDTH_DEF,
    parameter int FRAC_BITS = gtm_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // sample side
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [gtm_pkg::SAMPLE_W-1:0] i_sample,
    // result side
    output logic                              empty,
    input  wire logic                         pop,
    output logic      [gtm_pkg::MAG_W-1:0]    o_magnitude,
    output logic      [gtm_pkg::BAR_W-1:0]    o_bar_level,
    output logic                              o_tone_detected,
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [gtm_pkg::APB_AW-1:0]   paddr,
    input  wire logic [gtm_pkg::APB_DW-1:0]   pwdata,
    output logic      [gtm_pkg::APB_DW-1:0]   prdata,
    output logic                              pready
);
    import gtm_pkg::*;

    t_cfg                 w_cfg;
    t_item                w_item;
    logic                 w_q_empty;
    logic                 w_q_pop;
    logic                 w_hand_valid;
    logic                 w_hand_ready;
    logic [ACC_WIDTH-1:0] w_q1;
    logic [ACC_WIDTH-1:0] w_q2;
    logic                 w_out_valid;

    assign empty = ~w_out_valid;

    // configuration registers
    gtm_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    // sample intake and queue
    gtm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_sample       (i_sample),
        .i_block_length (w_cfg.block_length),
        .o_item         (w_item),
        .o_empty        (w_q_empty),
        .i_pop          (w_q_pop)
    );

    // recurrence engine
    gtm_mac #(
        .ACC_WIDTH (ACC_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_coeff      (w_cfg.coeff_q14),
        .i_item       (w_item),
        .i_q_empty    (w_q_empty),
        .o_q_pop      (w_q_pop),
        .o_hand_valid (w_hand_valid),
        .i_hand_ready (w_hand_ready),
        .o_q1         (w_q1),
        .o_q2         (w_q2)
    );

    // magnitude unit and result register
    gtm_mag #(
        .ACC_WIDTH (ACC_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_mag (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_valid         (w_hand_valid),
        .o_ready         (w_hand_ready),
        .i_q1            (w_q1),
        .i_q2            (w_q2),
        .o_out_valid     (w_out_valid),
        .i_out_pop       (pop),
        .o_magnitude     (o_magnitude),
        .o_bar_level     (o_bar_level),
        .o_tone_detected (o_tone_detected)
    );

endmodule

`default_nettype wire
